/* src/sitda_pkg.sv */
package sitda_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 6;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 6'd43;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

   // reciprocal of ten, exact for any 32-bit dividend with a shift of 35
   localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int                 RECIP_SH  = 35;

   typedef enum logic [1:0] {
      SIGN_NONE  = 2'd0,
      SIGN_PLUS  = 2'd1,
      SIGN_MINUS = 2'd2
   } sign_type;

   typedef struct packed {
      sign_type             sign;
      logic [VALUE_W-1:0]   mag;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* src/signed_int_to_decimal_ascii.sv */
// Channel   Ports                                   Direction
// req       req_valid req_stall req_cmd req_value   value in
// rsp       rsp_valid rsp_stall rsp_char_code rsp_last  characters out
//
// Front register and a two-entry queue take items while the back converts.
// Back: a load state, then one digit per cycle (divide by ten via a
// 32x32 reciprocal multiply), then one character per cycle out while
// rsp_stall is low; the next item is loaded once the last one is out.
// Synchronous active-high reset clears control; rsp_stall holds the output.
module signed_int_to_decimal_ascii #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [sitda_pkg::VALUE_W-1:0]  req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sitda_pkg::CHAR_W-1:0]          rsp_char_code,
   output logic                                  rsp_last
);

   sitda_pkg::queue_status_type q_status;
   sitda_pkg::job_type          push_job;
   sitda_pkg::job_type          pop_job;
   logic                        push;
   logic                        pop;

   sitda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   sitda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   sitda_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop_job       (pop_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

/* src/sitda_front.sv */
module sitda_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   input  sitda_pkg::queue_status_type   q_status,
   output logic                          push,
   output sitda_pkg::job_type            push_job
);

   logic               valid_ff, valid_in;
   sitda_pkg::job_type job_ff, job_in;
   logic               take;
   logic               negative;

   assign push      = valid_ff && !q_status.full;
   assign push_job  = job_ff;
   assign req_stall = valid_ff && q_status.full;
   assign take      = req_valid && !req_stall;
   assign negative  = req_value[sitda_pkg::VALUE_W-1];

   always_comb begin
      job_in = job_ff;
      if (take) begin
         if (negative) begin
            job_in.sign = sitda_pkg::SIGN_MINUS;
            job_in.mag  = sitda_pkg::VALUE_W'(0) - sitda_pkg::VALUE_W'(req_value);
         end else begin
            job_in.sign = req_cmd ? sitda_pkg::SIGN_PLUS : sitda_pkg::SIGN_NONE;
            job_in.mag  = sitda_pkg::VALUE_W'(req_value);
         end
      end
      valid_in = take || (valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

/* src/sitda_queue.sv */
module sitda_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sitda_pkg::job_type          push_job,
   input  logic                        pop,
   output sitda_pkg::job_type          pop_job,
   output sitda_pkg::queue_status_type status
);

   sitda_pkg::job_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_job      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* src/sitda_back.sv */
module sitda_back #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sitda_pkg::queue_status_type       q_status,
   input  sitda_pkg::job_type                pop_job,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sitda_pkg::CHAR_W-1:0]      rsp_char_code,
   output logic                              rsp_last
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int VW    = sitda_pkg::VALUE_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [VW-1:0]       mag_ff, mag_in;
   sitda_pkg::sign_type sign_ff, sign_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [3:0]          digit_store [MAX_DIGITS];
   logic [3:0]          digit_rd_ff;

   logic                       out_valid_ff, out_valid_in;
   logic [sitda_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic [2*VW-1:0] product;
   logic [VW-1:0]   quot;
   logic [VW-1:0]   rem_full;
   logic [3:0]      rem;
   logic            out_free;
   logic            conv_done;
   logic            wr_digit;

   // divide by ten through the reciprocal; remainder from q*10 by shifts
   assign product  = mag_ff * sitda_pkg::RECIP_TEN;
   assign quot     = VW'(product >> sitda_pkg::RECIP_SH);
   assign rem_full = mag_ff - ((quot << 3) + (quot << 1));
   assign rem      = rem_full[3:0];
   assign conv_done = (quot == '0) || (pos_ff == IDX_W'(MAX_DIGITS - 1));

   assign out_free      = !out_valid_ff || !rsp_stall;
   assign rsp_valid     = out_valid_ff;
   assign rsp_char_code = out_char_ff;
   assign rsp_last      = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      sign_in      = sign_ff;
      pos_in       = pos_ff;
      pop          = 1'b0;
      wr_digit     = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               mag_in   = pop_job.mag;
               sign_in  = pop_job.sign;
               pos_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            wr_digit = 1'b1;
            mag_in   = quot;
            if (conv_done) begin
               // pos stays on the most significant digit
               state_in = (sign_ff == sitda_pkg::SIGN_NONE) ? ST_DIGIT : ST_SIGN;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = (sign_ff == sitda_pkg::SIGN_MINUS) ?
                              sitda_pkg::CH_MINUS : sitda_pkg::CH_PLUS;
               out_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = sitda_pkg::CH_ZERO + sitda_pkg::CHAR_W'(digit_rd_ff);
               out_last_in  = (pos_ff == '0);
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      sign_ff     <= sign_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (wr_digit) begin
         digit_store[pos_ff] <= rem;
      end
      // the digit being written bypasses the store
      digit_rd_ff <= wr_digit ? rem : digit_store[pos_in];
   end

endmodule

/* tb/signed_int_to_decimal_ascii_tb.sv */
module signed_int_to_decimal_ascii_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIGITS  = 10;
   localparam int TEXT_W      = 8 * 11;
   localparam int IDLE_LIMIT  = 2000;
   localparam int RAND_ITEMS  = 188;
   localparam int DRAIN_CYC   = 40;
   localparam int HOLD_AT     = 500;
   localparam int HOLD_CYC    = 300;

   typedef struct packed {
      logic [sitda_pkg::CHAR_W-1:0] code;
      logic                         last;
   } ascii_char_type;

   // text of zero means the row is checked against the predictor
   typedef struct packed {
      logic                          cmd;
      logic [sitda_pkg::VALUE_W-1:0] value;
      logic [TEXT_W-1:0]             text;
   } dir_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic                                  req_cmd = 1'b0;
   logic signed [sitda_pkg::VALUE_W-1:0]  req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [sitda_pkg::CHAR_W-1:0]          rsp_char_code;
   logic                                  rsp_last;

   ascii_char_type    char_q[$];
   logic [TEXT_W-1:0] text_q[$];
   dir_row_type       dir_rows[$];
   int                err_count = 0;
   int                rsp_count = 0;
   int                idle_cycles = 0;

   signed_int_to_decimal_ascii #(.MAX_DIGITS(MAX_DIGITS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // decimal text of one value, sign first, least significant digit last
   function automatic void predict_chars(input logic cmd,
                                         input logic [sitda_pkg::VALUE_W-1:0] value);
      logic [sitda_pkg::VALUE_W-1:0] mag;
      logic [3:0]                    digits[MAX_DIGITS];
      logic [sitda_pkg::CHAR_W-1:0]  code;
      sitda_pkg::sign_type           sgn;
      int                            n;
      mag = value[sitda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      sgn = value[sitda_pkg::VALUE_W-1] ? sitda_pkg::SIGN_MINUS :
            (cmd ? sitda_pkg::SIGN_PLUS : sitda_pkg::SIGN_NONE);
      n = 0;
      do begin
         digits[n] = 4'(mag % 10);
         mag = mag / 10;
         n++;
      end while (mag != 0 && n < MAX_DIGITS);
      if (sgn == sitda_pkg::SIGN_MINUS) begin
         char_q.push_back(ascii_char_type'{sitda_pkg::CH_MINUS, 1'b0});
      end else if (sgn == sitda_pkg::SIGN_PLUS) begin
         char_q.push_back(ascii_char_type'{sitda_pkg::CH_PLUS, 1'b0});
      end
      for (int k = n - 1; k >= 0; k--) begin
         code = sitda_pkg::CH_ZERO + sitda_pkg::CHAR_W'(digits[k]);
         char_q.push_back(ascii_char_type'{code, k == 0});
      end
   endfunction

   // typed-in text is right justified, so its final character is byte 0
   function automatic void expect_text(input logic [TEXT_W-1:0] text);
      logic [7:0] c;
      for (int i = TEXT_W / 8 - 1; i >= 0; i--) begin
         c = text[i*8 +: 8];
         if (c != 8'd0) begin
            char_q.push_back(ascii_char_type'{c[sitda_pkg::CHAR_W-1:0], i == 0});
         end
      end
   endfunction

   function automatic logic [sitda_pkg::VALUE_W-1:0] random_value();
      longint lo;
      longint hi;
      longint v;
      int     d;
      v = 0;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: begin
            d = $urandom_range(1, 10);
            lo = 1;
            for (int i = 1; i < d; i++) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            v = lo + ({$urandom, $urandom} % (hi - lo + 1));
            if ($urandom_range(0, 1)) v = -v;
         end
         2: begin
            lo = 1;
            d = $urandom_range(0, 9);
            for (int i = 0; i < d; i++) lo = lo * 10;
            v = lo + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         3: begin
            v = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            if ($urandom_range(0, 1)) v = 64'h8000_0000 + $urandom_range(0, 3);
            else v = 64'h7FFF_FFFF - $urandom_range(0, 3);
         end
      endcase
      return v[sitda_pkg::VALUE_W-1:0];
   endfunction

   task automatic offer_item(input logic cmd, input logic [sitda_pkg::VALUE_W-1:0] value,
                             input logic [TEXT_W-1:0] text, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      text_q.push_back(text);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int gap;
      dir_rows.push_back(dir_row_type'{1'b0, 32'h0000_0000, TEXT_W'("0")});
      dir_rows.push_back(dir_row_type'{1'b1, 32'h0000_0000, TEXT_W'("+0")});
      dir_rows.push_back(dir_row_type'{1'b0, 32'h8000_0000, TEXT_W'("-2147483648")});
      dir_rows.push_back(dir_row_type'{1'b1, 32'h8000_0000, TEXT_W'("-2147483648")});
      dir_rows.push_back(dir_row_type'{1'b0, 32'h7FFF_FFFF, TEXT_W'("2147483647")});
      dir_rows.push_back(dir_row_type'{1'b1, 32'h7FFF_FFFF, TEXT_W'("+2147483647")});
      dir_rows.push_back(dir_row_type'{1'b0, 32'hFFFF_FFFF, TEXT_W'("-1")});
      dir_rows.push_back(dir_row_type'{1'b1, 32'hFFFF_FFFF, TEXT_W'("-1")});
      dir_rows.push_back(dir_row_type'{1'b0, 32'h0000_0001, TEXT_W'("1")});
      dir_rows.push_back(dir_row_type'{1'b1, 32'h0000_0001, TEXT_W'("+1")});
      dir_rows.push_back(dir_row_type'{1'b0, 32'd9, '0});
      dir_rows.push_back(dir_row_type'{1'b1, 32'd10, '0});
      dir_rows.push_back(dir_row_type'{1'b0, 32'hFFFF_FFF6, '0});
      dir_rows.push_back(dir_row_type'{1'b1, 32'd99, '0});
      dir_rows.push_back(dir_row_type'{1'b0, 32'd100, '0});
      dir_rows.push_back(dir_row_type'{1'b0, 32'd999999999, '0});
      dir_rows.push_back(dir_row_type'{1'b1, 32'd1000000000, '0});
      dir_rows.push_back(dir_row_type'{1'b0, 32'hC465_3600, '0});
      dir_rows.push_back(dir_row_type'{1'b0, 32'h5555_5555, '0});
      dir_rows.push_back(dir_row_type'{1'b1, 32'hAAAA_AAAA, '0});
      dir_rows.push_back(dir_row_type'{1'b0, 32'h8000_0001, '0});
      dir_rows.push_back(dir_row_type'{1'b1, 32'h7FFF_FFFE, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         offer_item(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].text,
                    $urandom_range(0, 9));
      end

      for (int i = 0; i < RAND_ITEMS; i++) begin
         // a stretch of back-to-back items, otherwise random gaps
         gap = (i >= 40 && i < 70) ? 0 : $urandom_range(0, 9);
         if (i == 120) begin
            req_valid <= 1'b0;
            while (char_q.size() != 0 || text_q.size() != 0) @(posedge clock);
            gap = 0;
         end
         offer_item(1'($urandom_range(0, 1)), random_value(), '0, gap);
      end
      req_valid <= 1'b0;

      while (char_q.size() != 0 || text_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // receiver: random stall per item, a calm stretch now and then, one long hold
   initial begin
      int  hold;
      bit  held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count >= HOLD_AT && !held) begin
            held = 1'b1;
            hold = HOLD_CYC;
         end else if ((rsp_count % 300) < 60) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : monitor
      logic [TEXT_W-1:0] txt;
      ascii_char_type    want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            txt = text_q.pop_front();
            if (txt != '0) begin
               expect_text(txt);
            end else begin
               predict_chars(req_cmd, req_value);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (char_q.size() == 0) begin
               $display("%0t: unexpected item char_code %0d last %0b",
                        $time, rsp_char_code, rsp_last);
               err_count++;
            end else begin
               want = char_q.pop_front();
               if (rsp_char_code !== want.code) begin
                  $display("%0t: char_code expected %0d actual %0d",
                           $time, want.code, rsp_char_code);
                  err_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_last);
                  err_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule
